[rtl/core/assert_macros.svh]
// assertion macros for the scheduler assertion module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MLQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define MLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/mlq_sbs_pkg.sv]
package mlq_sbs_pkg;

    // default sizing
    localparam int NUM_PRIO_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // request kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_PUT  = 2'd1;
    localparam logic [1:0] KIND_GET  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // request beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] proc_id;
        logic [2:0] prio;
    } mlq_req_t;

    // response beat
    typedef struct packed {
        logic       got_proc;
        logic [7:0] out_proc_id;
        logic       dropped;
        logic       all_empty;
    } mlq_rsp_t;

endpackage

[rtl/core/mlq_slot_budget_scheduler_unit.sv]
// add/put pass S_PUSH, then S_DONE; kind 3 goes straight to S_DONE; get scans
// one level per cycle in S_SCAN from level 0 up, then passes S_REFILL, S_DONE;
// no new request is taken before the last response is registered, and the id
// store has one port, shared by enqueue writes and dequeue reads
// rst_n clears control, fifo pointers, counts, budgets and first-add marks;
// the id store is not cleared, only written entries are ever read back
module mlq_slot_budget_scheduler_unit
    import mlq_sbs_pkg::*;
#(
    parameter int NUM_PRIO    = NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  mlq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output mlq_rsp_t rsp
);

    localparam int LVL_W     = $clog2(NUM_PRIO);
    localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int BUD_W     = $clog2(NUM_PRIO + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int MEM_DEPTH = NUM_PRIO * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [3:0]       NUM_PRIO_L = 4'(NUM_PRIO);
    localparam logic [LVL_W-1:0] LAST_LVL   = LVL_W'(NUM_PRIO - 1);
    localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(QUEUE_DEPTH);
    localparam logic [HEAD_W-1:0] LAST_SLOT = HEAD_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_REFILL,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           kind_reg, kind_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [LVL_W-1:0]     idx_reg, idx_next;
    logic                 got_reg, got_next;
    logic                 drop_reg, drop_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    mlq_rsp_t             rsp_reg, rsp_next;

    logic [HEAD_W-1:0]    head_reg   [NUM_PRIO];
    logic [HEAD_W-1:0]    head_next  [NUM_PRIO];
    logic [CNT_W-1:0]     count_reg  [NUM_PRIO];
    logic [CNT_W-1:0]     count_next [NUM_PRIO];
    logic [BUD_W-1:0]     budget_reg [NUM_PRIO];
    logic [BUD_W-1:0]     budget_next[NUM_PRIO];
    logic                 seen_reg   [NUM_PRIO];
    logic                 seen_next  [NUM_PRIO];

    // id store, one region of QUEUE_DEPTH entries per level
    logic [ID_BITS-1:0]   id_mem [MEM_DEPTH];
    logic [ID_BITS-1:0]   rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;

    logic [HEAD_W-1:0]    cur_head;
    logic [CNT_W-1:0]     cur_count;
    logic [BUD_W-1:0]     cur_budget;
    logic [SUM_W-1:0]     push_sum;
    logic [SUM_W-1:0]     push_wrap;
    logic [HEAD_W-1:0]    slot;
    logic                 prio_ok;
    logic [LVL_W+2:0]     prio_wide;
    logic [ID_BITS+7:0]   in_id_wide;
    logic [ID_BITS+7:0]   out_id_wide;
    logic                 any_count;
    logic                 any_budget;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // selected level view
    assign cur_head   = head_reg[idx_reg];
    assign cur_count  = count_reg[idx_reg];
    assign cur_budget = budget_reg[idx_reg];

    // tail slot of the selected fifo in S_PUSH, head slot otherwise
    assign push_sum  = SUM_W'(cur_head) + SUM_W'(cur_count);
    assign push_wrap = (push_sum >= DEPTH_SUM) ? (push_sum - DEPTH_SUM) : push_sum;
    assign slot      = (state_reg == S_PUSH) ? push_wrap[HEAD_W-1:0] : cur_head;
    assign mem_addr  = ADDR_W'(idx_reg) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

    // request field resizing
    assign prio_ok     = ({1'b0, req.prio} < NUM_PRIO_L);
    assign prio_wide   = {{LVL_W{1'b0}}, req.prio};
    assign in_id_wide  = {{ID_BITS{1'b0}}, req.proc_id};
    assign out_id_wide = {8'b0, id_reg};

    // occupancy and budget summaries
    always_comb
    begin
        any_count  = 1'b0;
        any_budget = 1'b0;
        for (int i = 0; i < NUM_PRIO; i++)
        begin
            any_count  = any_count | (count_reg[i] != '0);
            any_budget = any_budget | (budget_reg[i] != '0);
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        idx_next       = idx_reg;
        got_next       = got_reg;
        drop_next      = drop_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        budget_next    = budget_reg;
        seen_next      = seen_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    id_next   = in_id_wide[ID_BITS-1:0];
                    got_next  = 1'b0;
                    drop_next = 1'b0;
                    unique case (req.kind)
                        KIND_ADD, KIND_PUT:
                        begin
                            idx_next   = prio_wide[LVL_W-1:0];
                            drop_next  = !prio_ok;
                            state_next = S_PUSH;
                        end
                        KIND_GET:
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                if (drop_reg || cur_count == FULL_CNT)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    mem_we              = 1'b1;
                    count_next[idx_reg] = cur_count + 1'b1;
                    // first add that finds the level empty arms its budget
                    if (kind_reg == KIND_ADD && cur_count == '0 && !seen_reg[idx_reg])
                    begin
                        budget_next[idx_reg] = BUD_W'(NUM_PRIO) - BUD_W'(idx_reg);
                        seen_next[idx_reg]   = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // one level per cycle, highest priority first
                if (cur_count != '0 && cur_budget != '0)
                begin
                    mem_re               = 1'b1;
                    head_next[idx_reg]   = (cur_head == LAST_SLOT) ? '0 : cur_head + 1'b1;
                    count_next[idx_reg]  = cur_count - 1'b1;
                    budget_next[idx_reg] = cur_budget - 1'b1;
                    got_next             = 1'b1;
                    state_next           = S_REFILL;
                end
                else if (idx_reg == LAST_LVL)
                begin
                    state_next = S_REFILL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REFILL:
            begin
                if (!any_budget)
                begin
                    for (int i = 0; i < NUM_PRIO; i++)
                    begin
                        budget_next[i] = BUD_W'(NUM_PRIO - i);
                    end
                end
                if (got_reg)
                begin
                    id_next = rd_data_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.got_proc    = got_reg;
                    rsp_next.out_proc_id = got_reg ? out_id_wide[7:0] : 8'd0;
                    rsp_next.dropped     = drop_reg;
                    rsp_next.all_empty   = !any_count;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            got_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            for (int i = 0; i < NUM_PRIO; i++)
            begin
                head_reg[i]   <= '0;
                count_reg[i]  <= '0;
                budget_reg[i] <= '0;
                seen_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            got_reg       <= got_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            budget_reg    <= budget_next;
            seen_reg      <= seen_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        idx_reg  <= idx_next;
    end

    // id store port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[mem_addr] <= id_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= id_mem[mem_addr];
        end
    end

endmodule

[rtl/core/mlq_sbs_checker.sv]
`include "assert_macros.svh"

module mlq_sbs_assert
    import mlq_sbs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input mlq_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input mlq_rsp_t rsp
);

    // a stalled response beat holds
    `MLQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // an accepted request leaves the block busy in the cycle after it
    `MLQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // no id is reported unless a process was dequeued
    `MLQ_ASSERT_IMPLY(a_id_zero, clk, rst_n, rsp_valid && !rsp.got_proc, rsp.out_proc_id == 8'd0)

    // a dequeue never reports a dropped enqueue
    `MLQ_ASSERT_IMPLY(a_got_not_drop, clk, rst_n, rsp_valid && rsp.got_proc, !rsp.dropped)

endmodule

bind mlq_slot_budget_scheduler_unit mlq_sbs_assert u_mlq_sbs_assert (.*);

[sim/mlq_sbs_checker.sv]
`timescale 1ns / 1ps

// watches both channels, predicts each response beat and compares it
module mlq_sbs_checker
    import mlq_sbs_pkg::*;
#(
    parameter int NUM_PRIO    = NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  mlq_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  mlq_rsp_t rsp,
    output int       error_count,
    output int       outstanding
);

    localparam logic [7:0] ID_MASK = 8'((1 << ID_BITS) - 1);

    // shadow copy of the ready queues
    logic [7:0]  id_store [NUM_PRIO][QUEUE_DEPTH];
    int unsigned lvl_head   [NUM_PRIO];
    int unsigned lvl_count  [NUM_PRIO];
    int unsigned lvl_budget [NUM_PRIO];
    bit          lvl_seen   [NUM_PRIO];

    // responses still owed by the block, oldest first
    mlq_rsp_t owed_rsp [$];

    initial error_count = 0;

    // apply one request beat to the shadow queues, return the response it earns
    function automatic mlq_rsp_t schedule_step(mlq_req_t r);
        mlq_rsp_t    res;
        int          lvl;
        int unsigned slot;
        bit          served;
        bit          spent;
        res = '0;
        lvl = int'(r.prio);
        case (r.kind)
            KIND_ADD, KIND_PUT:
            begin
                if (lvl >= NUM_PRIO || lvl_count[lvl] >= QUEUE_DEPTH)
                    res.dropped = 1'b1;
                else
                begin
                    slot = (lvl_head[lvl] + lvl_count[lvl]) % QUEUE_DEPTH;
                    id_store[lvl][slot] = r.proc_id & ID_MASK;
                    lvl_count[lvl]++;
                    // first add that finds the level empty arms its budget, once only
                    if (r.kind == KIND_ADD && lvl_count[lvl] == 1 && !lvl_seen[lvl])
                    begin
                        lvl_budget[lvl] = NUM_PRIO - lvl;
                        lvl_seen[lvl]   = 1'b1;
                    end
                end
            end
            KIND_GET:
            begin
                served = 1'b0;
                for (int i = 0; i < NUM_PRIO; i++)
                begin
                    if (!served && lvl_count[i] != 0 && lvl_budget[i] > 0)
                    begin
                        res.got_proc    = 1'b1;
                        res.out_proc_id = id_store[i][lvl_head[i]];
                        lvl_head[i]     = (lvl_head[i] + 1) % QUEUE_DEPTH;
                        lvl_count[i]--;
                        lvl_budget[i]--;
                        served = 1'b1;
                    end
                end
                // refill only once every budget is spent, empty levels included
                spent = 1'b1;
                for (int i = 0; i < NUM_PRIO; i++)
                    if (lvl_budget[i] != 0)
                        spent = 1'b0;
                if (spent)
                    for (int i = 0; i < NUM_PRIO; i++)
                        lvl_budget[i] = NUM_PRIO - i;
            end
            default: ;
        endcase
        res.all_empty = 1'b1;
        for (int i = 0; i < NUM_PRIO; i++)
            if (lvl_count[i] != 0)
                res.all_empty = 1'b0;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // pop on response beats, predict on request beats
    always @(posedge clk or negedge rst_n)
    begin
        mlq_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PRIO; i++)
            begin
                lvl_head[i]   = 0;
                lvl_count[i]  = 0;
                lvl_budget[i] = 0;
                lvl_seen[i]   = 1'b0;
            end
            owed_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("response beat with nothing pending: got_proc %0d id %0d",
                           rsp.got_proc, rsp.out_proc_id);
                    error_count++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("got_proc", 8'(want.got_proc), 8'(rsp.got_proc));
                    check_field("out_proc_id", want.out_proc_id, rsp.out_proc_id);
                    check_field("dropped", 8'(want.dropped), 8'(rsp.dropped));
                    check_field("all_empty", 8'(want.all_empty), 8'(rsp.all_empty));
                end
            end
            if (req_valid && req_ready)
                owed_rsp.push_back(schedule_step(req));
            outstanding <= owed_rsp.size();
        end
    end

endmodule

[sim/mlq_slot_budget_scheduler_unit_tb.sv]
`timescale 1ns / 1ps

module mlq_slot_budget_scheduler_unit_tb
    import mlq_sbs_pkg::*;
;

    localparam int RAND_ITEMS     = 1025;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    mlq_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    mlq_rsp_t rsp;

    int error_count;
    int outstanding;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;

    always #5 clk = ~clk;

    mlq_slot_budget_scheduler_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    mlq_sbs_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic mlq_req_t mk_req(logic [1:0] kind, logic [7:0] id, logic [2:0] prio);
        mlq_req_t b;
        b.kind    = kind;
        b.proc_id = id;
        b.prio    = prio;
        return b;
    endfunction

    // drive one request beat after an optional gap, return once it is taken
    task automatic send_beat(input mlq_req_t beat, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= beat;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // hold off the sender until every owed response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // response side back-pressure with calm stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 5)
                calm_left = $urandom_range(50, 300);
            else if ($urandom_range(0, 99) < 35)
                stall_left = pick_gap();
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** mlq_slot_budget_scheduler_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int         sent;
        int         style;
        int         len;
        int         r;
        bit         steady;
        logic [2:0] lvl;
        logic [1:0] kind;
        logic [2:0] prio;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused kind and a get while everything is empty
        send_beat(mk_req(KIND_NONE, 8'hA5, 3'd7), pick_gap());
        send_beat(mk_req(KIND_GET, 8'hFF, 3'd7), pick_gap());
        // first adds arm budgets at both ends of the priority range
        send_beat(mk_req(KIND_ADD, 8'hFF, 3'd0), pick_gap());
        send_beat(mk_req(KIND_ADD, 8'h00, 3'd7), pick_gap());
        send_beat(mk_req(KIND_PUT, 8'h5A, 3'd7), pick_gap());
        // serve level 0, spend level 7, then an empty level blocks the refill
        send_beat(mk_req(KIND_GET, 8'h00, 3'd0), pick_gap());
        send_beat(mk_req(KIND_GET, 8'hFF, 3'd5), pick_gap());
        send_beat(mk_req(KIND_GET, 8'h33, 3'd2), pick_gap());
        // fill one level and overflow it
        for (int k = 0; k < 17; k++)
            send_beat(mk_req(KIND_PUT, 8'($urandom_range(0, 255)), 3'd3), pick_gap());
        wait_drained();

        // random bursts: fills, drains, mixed traffic and noise
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            style  = $urandom_range(0, 99);
            steady = ($urandom_range(0, 3) == 0);
            lvl    = 3'($urandom_range(0, NUM_PRIO_DEF - 1));
            len    = $urandom_range(1, 24);
            for (int k = 0; k < len && sent < RAND_ITEMS; k++)
            begin
                prio = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 2))
                                                   : 3'($urandom_range(0, 7));
                if (style < 20)
                begin
                    kind = ($urandom_range(0, 3) == 0) ? KIND_ADD : KIND_PUT;
                    if ($urandom_range(0, 7) != 0)
                        prio = lvl;
                end
                else if (style < 40)
                    kind = KIND_GET;
                else if (style < 90)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        kind = KIND_ADD;
                    else if (r < 55)
                        kind = KIND_PUT;
                    else if (r < 95)
                        kind = KIND_GET;
                    else
                        kind = KIND_NONE;
                end
                else
                begin
                    kind = 2'($urandom_range(0, 3));
                    prio = 3'($urandom_range(0, 7));
                end
                send_beat(mk_req(kind, 8'($urandom_range(0, 255)), prio),
                          steady ? 0 : pick_gap());
                if (kind != KIND_NONE)
                    sent++;
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        // let the last responses come home
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** mlq_slot_budget_scheduler_unit: PASSED **");
        else
            $display("** mlq_slot_budget_scheduler_unit: FAILED **");
        $finish;
    end

endmodule
